// ===== rtl/plpe_pkg.sv =====
// Shared types and constants for the parallel LED pulse encoder.
// Used by the controller, datapath, frame store and top level; no dependencies.
package plpe_pkg;

  // Sizing of the frame store.
  localparam int MAX_LEDS = 512;
  localparam int CHANNELS = 8;

  // LED index width inside one buffer, and the address width of one channel bank
  // holding both buffers.
  localparam int LED_W  = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int ADDR_W = LED_W + 1;
  localparam int DEPTH  = 2 ** ADDR_W;

  // Width that can hold the clamped pixel count itself.
  localparam int PIX_W = $clog2(MAX_LEDS + 1);

  // Number of strands that reach the eight output lines.
  localparam int LINE_CH = (CHANNELS < 8) ? CHANNELS : 8;

  // Stream payload widths.
  localparam int IN_DATA_W  = 48;
  localparam int OP_W       = 2;
  localparam int OUT_DATA_W = 8;
  localparam int WORD_W     = 32;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] REG_COMPONENTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXELS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH      = 2'd2;

  // Item kinds carried in tuser.
  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_SHOW  = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef logic [WORD_W-1:0] word_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic clear;  // write zeros at the sweep address
    logic take;   // an input beat is accepted this cycle
    logic load;   // fill the output register with the pending slot
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clear_done;   // sweep address is at the last entry
    logic tick_seen;    // offered beat is a tick
    logic out_blocked;  // output register full and not taken
  } stat_t;

endpackage

// ===== rtl/parallel_led_pulse_encoder_top.sv =====
// Parallel LED pulse encoder (plpe_ctrl, plpe_datapath, plpe_store, plpe_pkg).
// Write and show beats are taken one per cycle while no tick is pending. A tick beat's
// read data is registered in the frame store and its slot is then loaded into the output
// register; the next beat is taken only after that load, and a stalled output holds
// in_tready low. After reset a clearing pass zeros all rows with in_tready low;
// configuration writes are taken throughout.
module parallel_led_pulse_encoder_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [2:0] channel, [11:3] led_index, [43:12] color, [47:44] zero
  input  logic [plpe_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] operation
  input  logic [plpe_pkg::OP_W-1:0]       in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [7:0] lines
  output logic [plpe_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [plpe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [plpe_pkg::CFG_DATA_W-1:0] cfg_data
);
  import plpe_pkg::*;

  cmd_t              cmd;
  stat_t             stat;
  logic [CHANNELS-1:0] mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  word_t             mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  word_t             mem_rdata [CHANNELS];

  // Sequencing of beats and the clearing pass.
  plpe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Counters, registers and output slot.
  plpe_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  // Double-buffered frame memory.
  plpe_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ===== rtl/plpe_store.sv =====
// Frame store: one bank per channel, both buffers in each bank.
// Per-bank write enables, one shared read address with registered read data.
// Depends on plpe_pkg.
module plpe_store (
  input  logic                        clk,
  input  logic [plpe_pkg::CHANNELS-1:0] we,
  input  logic [plpe_pkg::ADDR_W-1:0] waddr,
  input  plpe_pkg::word_t             wdata,
  input  logic                        re,
  input  logic [plpe_pkg::ADDR_W-1:0] raddr,
  output plpe_pkg::word_t             rdata [plpe_pkg::CHANNELS]
);
  import plpe_pkg::*;

  word_t mem [CHANNELS][DEPTH];

  // Each bank is written at one address and read at one address per cycle.
  always_ff @(posedge clk) begin
    for (int c = 0; c < CHANNELS; c++) begin
      if (we[c]) begin
        mem[c][waddr] <= wdata;
      end
      if (re) begin
        rdata[c] <= mem[c][raddr];
      end
    end
  end

endmodule

// ===== rtl/plpe_ctrl.sv =====
// Controller for the LED pulse encoder: clearing sweep, beat acceptance and
// the wait for frame store read data. Depends on plpe_pkg.
module plpe_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  plpe_pkg::stat_t stat,
  output plpe_pkg::cmd_t  cmd
);
  import plpe_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ
  } state_t;

  state_t state_r, state_nxt;
  logic   ready_r, ready_nxt;

  assign in_tready = ready_r;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd.take = ready_r && in_tvalid;
        if (cmd.take && stat.tick_seen) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (!stat.out_blocked) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
    ready_nxt = (state_nxt == ST_IDLE);
  end

  // State and registered ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      ready_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ready_r <= ready_nxt;
    end
  end

endmodule

// ===== rtl/plpe_datapath.sv =====
// Datapath for the LED pulse encoder: configuration registers, slot position
// counters, buffer select, store addressing and the output register.
// Depends on plpe_pkg; drives the plpe_store ports.
module plpe_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  plpe_pkg::cmd_t                  cmd,
  output plpe_pkg::stat_t                 stat,
  input  logic [plpe_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [plpe_pkg::OP_W-1:0]       in_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [plpe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [plpe_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [plpe_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  output logic [plpe_pkg::CHANNELS-1:0]   mem_we,
  output logic [plpe_pkg::ADDR_W-1:0]     mem_waddr,
  output plpe_pkg::word_t                 mem_wdata,
  output logic                            mem_re,
  output logic [plpe_pkg::ADDR_W-1:0]     mem_raddr,
  input  plpe_pkg::word_t                 mem_rdata [plpe_pkg::CHANNELS]
);
  import plpe_pkg::*;

  typedef enum logic [1:0] {
    SLOT_LOW,
    SLOT_HIGH,
    SLOT_DATA
  } slot_t;

  // Beat fields.
  op_t         op;
  logic [2:0]  in_channel;
  logic [8:0]  in_led;
  word_t       in_color;

  assign op         = op_t'(in_tuser);
  assign in_channel = in_tdata[2:0];
  assign in_led     = in_tdata[11:3];
  assign in_color   = in_tdata[43:12];

  // Configuration registers.
  logic [2:0]  comp_used_r, comp_used_nxt;
  logic [9:0]  pixel_cnt_r, pixel_cnt_nxt;
  logic [11:0] latch_slots_r, latch_slots_nxt;

  // Frame position state.
  logic             front_r, front_nxt;
  logic             swap_r, swap_nxt;
  logic [LED_W-1:0] led_r, led_nxt;
  logic [1:0]       comp_r, comp_nxt;
  logic [2:0]       bit_r, bit_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [11:0]      latch_r, latch_nxt;
  logic             in_latch_r, in_latch_nxt;

  // Pending slot, waiting for read data.
  slot_t      kind_r, kind_nxt;
  logic [4:0] shift_r, shift_nxt;
  logic       fend_r, fend_nxt;

  // Output register and clearing sweep.
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_lines_r, out_lines_nxt;
  logic                  out_last_r, out_last_nxt;
  logic [ADDR_W-1:0]     clr_addr_r, clr_addr_nxt;

  logic             do_tick;
  logic             do_write;
  logic             frame_start;
  logic             front_eff;
  logic [2:0]       comps;
  logic [PIX_W-1:0] pixels;
  logic [11:0]      latch_sum;
  logic [OUT_DATA_W-1:0] line_mask;
  logic [OUT_DATA_W-1:0] data_lines;

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_lines_r;
  assign out_tlast  = out_last_r;

  assign stat.clear_done  = (clr_addr_r == ADDR_W'(DEPTH - 1));
  assign stat.tick_seen   = (op == OP_TICK);
  assign stat.out_blocked = out_valid_r && !out_tready;

  assign do_tick  = cmd.take && (op == OP_TICK);
  assign do_write = cmd.take && (op == OP_WRITE) && (32'(in_channel) < CHANNELS) &&
                    (32'(in_led) < MAX_LEDS);

  // Clamped register values and frame start detection.
  always_comb begin
    comps = (comp_used_r >= 3'd4) ? 3'd4 : 3'd3;
    if (pixel_cnt_r == 10'd0) begin
      pixels = PIX_W'(1);
    end else if (32'(pixel_cnt_r) > MAX_LEDS) begin
      pixels = PIX_W'(MAX_LEDS);
    end else begin
      pixels = PIX_W'(pixel_cnt_r);
    end
    frame_start = !in_latch_r && (led_r == '0) && (comp_r == 2'd0) &&
                  (bit_r == 3'd0) && (phase_r == 2'd0);
    front_eff   = (frame_start && swap_r) ? ~front_r : front_r;
    latch_sum   = latch_r + 12'd1;
  end

  // Frame store ports: sweep writes zeros to every bank, pixel writes hit one bank.
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      mem_we[c] = cmd.clear || (do_write && (32'(in_channel) == c));
    end
    mem_waddr = cmd.clear ? clr_addr_r : {~front_r, LED_W'(in_led)};
    mem_wdata = cmd.clear ? '0 : in_color;
    mem_re    = do_tick;
    mem_raddr = {front_eff, led_r};
  end

  // Configuration writes, show requests and slot position stepping.
  always_comb begin
    comp_used_nxt   = comp_used_r;
    pixel_cnt_nxt   = pixel_cnt_r;
    latch_slots_nxt = latch_slots_r;
    front_nxt       = front_r;
    swap_nxt        = swap_r;
    led_nxt         = led_r;
    comp_nxt        = comp_r;
    bit_nxt         = bit_r;
    phase_nxt       = phase_r;
    latch_nxt       = latch_r;
    in_latch_nxt    = in_latch_r;
    kind_nxt        = kind_r;
    shift_nxt       = shift_r;
    fend_nxt        = fend_r;
    clr_addr_nxt    = cmd.clear ? clr_addr_r + ADDR_W'(1) : clr_addr_r;

    if (cfg_valid) begin
      case (cfg_index)
        REG_COMPONENTS: comp_used_nxt   = cfg_data[2:0];
        REG_PIXELS:     pixel_cnt_nxt   = cfg_data[9:0];
        REG_LATCH:      latch_slots_nxt = cfg_data;
        default: begin
        end
      endcase
    end

    if (cmd.take && (op == OP_SHOW)) begin
      swap_nxt = 1'b1;
    end

    if (do_tick) begin
      // A pending swap lands on the first slot of a frame.
      if (frame_start && swap_r) begin
        front_nxt = ~front_r;
        swap_nxt  = 1'b0;
      end
      kind_nxt  = SLOT_LOW;
      fend_nxt  = 1'b0;
      // Bit offset is component * 8 + (7 - bit), MSB first.
      shift_nxt = {comp_r, ~bit_r};
      if (in_latch_r) begin
        if (latch_sum >= latch_slots_r) begin
          fend_nxt     = 1'b1;
          in_latch_nxt = 1'b0;
          latch_nxt    = 12'd0;
        end else begin
          latch_nxt = latch_sum;
        end
      end else begin
        case (phase_r)
          2'd0:    kind_nxt = SLOT_HIGH;
          2'd1:    kind_nxt = SLOT_DATA;
          default: kind_nxt = SLOT_LOW;
        endcase
        if (phase_r == 2'd2) begin
          phase_nxt = 2'd0;
          if (bit_r == 3'd7) begin
            bit_nxt = 3'd0;
            if (({1'b0, comp_r} + 3'd1) >= comps) begin
              comp_nxt = 2'd0;
              if ((PIX_W'(led_r) + PIX_W'(1)) >= pixels) begin
                led_nxt = '0;
                if (latch_slots_r == 12'd0) begin
                  fend_nxt = 1'b1;
                end else begin
                  in_latch_nxt = 1'b1;
                  latch_nxt    = 12'd0;
                end
              end else begin
                led_nxt = led_r + LED_W'(1);
              end
            end else begin
              comp_nxt = comp_r + 2'd1;
            end
          end else begin
            bit_nxt = bit_r + 3'd1;
          end
        end else begin
          phase_nxt = phase_r + 2'd1;
        end
      end
    end
  end

  // Slot levels from the pending kind and the registered read data.
  always_comb begin
    line_mask  = '0;
    data_lines = '0;
    for (int c = 0; c < LINE_CH; c++) begin
      line_mask[c]  = 1'b1;
      data_lines[c] = mem_rdata[c][shift_r];
    end
    out_valid_nxt = out_valid_r && !out_tready;
    out_lines_nxt = out_lines_r;
    out_last_nxt  = out_last_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = fend_r;
      case (kind_r)
        SLOT_HIGH: out_lines_nxt = line_mask;
        SLOT_DATA: out_lines_nxt = data_lines;
        default:   out_lines_nxt = '0;
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comp_used_r   <= 3'd3;
      pixel_cnt_r   <= 10'd512;
      latch_slots_r <= 12'd120;
      front_r       <= 1'b0;
      swap_r        <= 1'b0;
      led_r         <= '0;
      comp_r        <= 2'd0;
      bit_r         <= 3'd0;
      phase_r       <= 2'd0;
      latch_r       <= 12'd0;
      in_latch_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      clr_addr_r    <= '0;
    end else begin
      comp_used_r   <= comp_used_nxt;
      pixel_cnt_r   <= pixel_cnt_nxt;
      latch_slots_r <= latch_slots_nxt;
      front_r       <= front_nxt;
      swap_r        <= swap_nxt;
      led_r         <= led_nxt;
      comp_r        <= comp_nxt;
      bit_r         <= bit_nxt;
      phase_r       <= phase_nxt;
      latch_r       <= latch_nxt;
      in_latch_r    <= in_latch_nxt;
      out_valid_r   <= out_valid_nxt;
      clr_addr_r    <= clr_addr_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    shift_r     <= shift_nxt;
    fend_r      <= fend_nxt;
    out_lines_r <= out_lines_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

// ===== tb/parallel_led_pulse_encoder_top_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for parallel_led_pulse_encoder_top: streams write, show and tick
// beats, predicts every slot byte with its own frame store model and compares in order.
// Depends on plpe_pkg and the encoder RTL.
module parallel_led_pulse_encoder_top_test;
  import plpe_pkg::*;

  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
  localparam int CYCLE_LIMIT   = 250000;
  localparam int DRAIN_CYCLES  = 16;
  localparam int LONG_HOLD     = 400;
  localparam int HOLD_AFTER    = 40;
  localparam int SHOWN_REPORTS = 10;

  typedef struct {
    logic [OP_W-1:0] op;
    logic [2:0]      ch;
    logic [8:0]      led;
    logic [31:0]     color;
  } beat_t;

  typedef struct packed {
    logic [7:0] lines;
    logic       frame_end;
  } slot_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [OP_W-1:0]       in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  parallel_led_pulse_encoder_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Encoder model: both buffers, scan position and register copies.
  logic [31:0] pixel_words [2][CHANNELS][MAX_LEDS];
  logic        front_buf  = 1'b0;
  logic        swap_req   = 1'b0;
  logic        latching   = 1'b0;
  logic [11:0] latch_cnt  = '0;
  int unsigned led_pos    = 0;
  int unsigned comp_pos   = 0;
  int unsigned bit_pos    = 0;
  int unsigned phase_pos  = 0;
  logic [2:0]  comp_reg   = 3'd3;
  logic [9:0]  pix_reg    = 10'd512;
  logic [11:0] latch_reg  = 12'd120;

  beat_t pending_beats [$];
  slot_t expected_slots [$];
  beat_t cur_beat;

  int beats_queued  = 0;
  int useful_queued = 0;
  int beats_sent    = 0;
  int mismatch_cnt  = 0;
  int idle_pct      = 0;
  int send_gap      = 0;
  int stall_left    = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;
  int slots_taken   = 0;
  int cycle_cnt     = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report(input string what, input logic [31:0] exp_v, input logic [31:0] act_v);
    mismatch_cnt++;
    if (mismatch_cnt <= SHOWN_REPORTS)
      $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, exp_v, act_v);
  endtask

  // Advance the model by one accepted beat; a tick yields one expected slot.
  task automatic step_encoder(input beat_t b);
    int unsigned comps;
    int unsigned pixels;
    int unsigned shift;
    int          c;
    logic [7:0]  lv;
    logic        fe;
    lv = '0;
    fe = 1'b0;
    case (b.op)
      OP_WRITE: begin
        if (b.ch < CHANNELS && b.led < MAX_LEDS)
          pixel_words[~front_buf][b.ch][b.led] = b.color;
      end
      OP_SHOW: swap_req = 1'b1;
      OP_TICK: begin
        comps = (comp_reg >= 4) ? 4 : 3;
        pixels = 32'(pix_reg);
        if (pixels < 1) pixels = 1;
        if (pixels > MAX_LEDS) pixels = MAX_LEDS;
        // A pending swap lands on the first slot of a frame.
        if (!latching && led_pos == 0 && comp_pos == 0 && bit_pos == 0 && phase_pos == 0
            && swap_req) begin
          front_buf = ~front_buf;
          swap_req = 1'b0;
        end
        if (latching) begin
          latch_cnt = latch_cnt + 12'd1;
          if (latch_cnt >= latch_reg) begin
            fe = 1'b1;
            latching = 1'b0;
            latch_cnt = '0;
          end
        end else begin
          if (phase_pos == 0) begin
            for (c = 0; c < LINE_CH; c++) lv[c] = 1'b1;
          end else if (phase_pos == 1) begin
            shift = (comp_pos % 4) * 8 + (7 - (bit_pos % 8));
            for (c = 0; c < LINE_CH; c++)
              lv[c] = pixel_words[front_buf][c][led_pos % MAX_LEDS][shift];
          end
          phase_pos++;
          if (phase_pos >= 3) begin
            phase_pos = 0;
            bit_pos++;
            if (bit_pos >= 8) begin
              bit_pos = 0;
              comp_pos++;
              if (comp_pos >= comps) begin
                comp_pos = 0;
                led_pos++;
                if (led_pos >= pixels) begin
                  led_pos = 0;
                  if (latch_reg == 0) begin
                    fe = 1'b1;
                  end else begin
                    latching = 1'b1;
                    latch_cnt = '0;
                  end
                end
              end
            end
          end
        end
        expected_slots.push_back('{lines: lv, frame_end: fe});
      end
      default: ;
    endcase
  endtask

  // Input driver: takes beats from the pending queue, with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        step_encoder(cur_beat);
        beats_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_beats.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
          send_gap = $urandom_range(1, 18) - 1;
          in_tvalid <= 1'b0;
        end else begin
          cur_beat = pending_beats.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {4'b0, cur_beat.color, cur_beat.led, cur_beat.ch};
          in_tuser <= cur_beat.op;
        end
      end
    end
  end

  // Result side ready: random stalls plus one long hold-off to back up the input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) slots_taken++;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!hold_done && slots_taken >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(1, 18) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Monitor: every slot beat is checked against the oldest expectation.
  always @(posedge clk) begin
    slot_t exp_s;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_slots.size() == 0) begin
        report("unexpected slot", '0, 32'({out_tlast, out_tdata}));
      end else begin
        exp_s = expected_slots.pop_front();
        if (out_tdata !== exp_s.lines)
          report("lines", 32'(exp_s.lines), 32'(out_tdata));
        if (out_tlast !== exp_s.frame_end)
          report("frame_end", 32'(exp_s.frame_end), 32'(out_tlast));
      end
    end
  end

  task automatic queue_beat(input logic [OP_W-1:0] op, input logic [2:0] ch,
                            input logic [8:0] led, input logic [31:0] color);
    pending_beats.push_back('{op: op, ch: ch, led: led, color: color});
    beats_queued++;
    if (op != OP_RESERVED) useful_queued++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_COMPONENTS: comp_reg = val[2:0];
      REG_PIXELS:     pix_reg = val[9:0];
      REG_LATCH:      latch_reg = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // Wait until every beat is in and every slot is out, then let the pipeline empty.
  task automatic settle();
    while (beats_sent != beats_queued || expected_slots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly frame refreshes (writes, a show, a run of ticks), some loose beats.
  task automatic random_phase(input int n, input int span);
    int target;
    int k;
    target = useful_queued + n;
    while (useful_queued < target) begin
      if ($urandom_range(0, 9) < 7) begin
        k = $urandom_range(0, 4);
        repeat (k) queue_beat(OP_WRITE, 3'($urandom), 9'($urandom_range(0, span)), $urandom);
        if ($urandom_range(0, 3) != 0)
          queue_beat(OP_SHOW, 3'($urandom), 9'($urandom), $urandom);
        k = $urandom_range(4, 40);
        repeat (k) queue_beat(OP_TICK, 3'($urandom), 9'($urandom), $urandom);
      end else begin
        queue_beat(OP_W'($urandom_range(0, 3)), 3'($urandom), 9'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    foreach (pixel_words[b, c, l]) pixel_words[b][c][l] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, ignored beats, double show, then the first slots.
    idle_pct = 10;
    queue_beat(OP_WRITE, 3'd0, 9'd0, 32'hFFFF_FFFF);
    queue_beat(OP_WRITE, 3'd7, 9'd0, 32'h0000_00A5);
    queue_beat(OP_WRITE, 3'd3, 9'd0, 32'h0000_0080);
    queue_beat(OP_WRITE, 3'd7, 9'd511, 32'hFFFF_FFFF);
    queue_beat(OP_WRITE, 3'd0, 9'd511, 32'h0000_0000);
    queue_beat(OP_WRITE, 3'd5, 9'd1, 32'h1234_5678);
    queue_beat(OP_RESERVED, 3'd7, 9'd511, 32'hFFFF_FFFF);
    queue_beat(OP_SHOW, 3'd0, 9'd0, 32'h0);
    queue_beat(OP_SHOW, 3'd7, 9'd511, 32'hFFFF_FFFF);
    repeat (12) queue_beat(OP_TICK, 3'd0, 9'd0, 32'h0);
    queue_beat(OP_WRITE, 3'd0, 9'd0, 32'h0000_0000);
    repeat (3) queue_beat(OP_TICK, 3'd7, 9'd511, 32'hFFFF_FFFF);
    settle();

    // RGBW, two LEDs, no latch gap.
    write_reg(REG_COMPONENTS, 12'd4);
    write_reg(REG_PIXELS, 12'd2);
    write_reg(REG_LATCH, 12'd0);
    random_phase(62, 3);
    settle();

    // Low component count, pixel count wrapping to zero, longest latch gap.
    idle_pct = 0;
    write_reg(REG_COMPONENTS, 12'd0);
    write_reg(REG_PIXELS, 12'd1024);
    write_reg(REG_LATCH, 12'd4095);
    random_phase(62, 1);
    settle();

    // Shrinking the gap mid-latch ends it once the latch count reaches the new gap.
    idle_pct = 30;
    write_reg(REG_COMPONENTS, 12'hFFF);
    write_reg(REG_PIXELS, 12'd3);
    write_reg(REG_LATCH, 12'd3);
    random_phase(62, 4);
    settle();

    // Pixel count above the store size acts as full length.
    idle_pct = 10;
    write_reg(REG_COMPONENTS, 12'd3);
    write_reg(REG_PIXELS, 12'd1023);
    write_reg(REG_LATCH, 12'd120);
    random_phase(62, 8);
    settle();

    // Closing stretch with both sides always ready.
    idle_pct = 0;
    write_reg(REG_PIXELS, 12'd1);
    write_reg(REG_LATCH, 12'd2);
    write_reg(REG_COMPONENTS, 12'd4);
    random_phase(62, 2);
    settle();

    if (mismatch_cnt == 0 && expected_slots.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
